### rtl/mdr_pkg.sv
`default_nettype none

package mdr_pkg;

  // Datapath width of the duty, target and configuration values
  localparam int unsigned DUTY_WIDTH = 16;
  localparam logic [DUTY_WIDTH-1:0] DUTY_MAX = {DUTY_WIDTH{1'b1}};

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_WIDTH = 2;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RAMP_STEP  = 2'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_DUTY_FLOOR = 2'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_TEST_DUTY  = 2'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_FAULT_HOLD = 2'd3;

  // Configuration reset values
  localparam logic [DUTY_WIDTH-1:0] RAMP_STEP_RST  = 16'd16;
  localparam logic [DUTY_WIDTH-1:0] DUTY_FLOOR_RST = 16'd0;
  localparam logic [DUTY_WIDTH-1:0] TEST_DUTY_RST  = 16'd0;
  localparam logic [DUTY_WIDTH-1:0] FAULT_HOLD_RST = 16'd1000;

  // Reported motor state codes
  localparam logic [1:0] MST_STOPPED  = 2'd0;
  localparam logic [1:0] MST_STARTING = 2'd1;
  localparam logic [1:0] MST_RUNNING  = 2'd2;
  localparam logic [1:0] MST_FAULT    = 2'd3;

  // Drive commands
  localparam logic [1:0] DRV_NONE    = 2'd0;
  localparam logic [1:0] DRV_DISABLE = 2'd1;
  localparam logic [1:0] DRV_ENABLE  = 2'd2;
  localparam logic [1:0] DRV_RESET   = 2'd3;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] ramp_step;
    logic [DUTY_WIDTH-1:0] duty_floor;
    logic [DUTY_WIDTH-1:0] test_duty;
    logic [DUTY_WIDTH-1:0] fault_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic                  start_cmd;
    logic [DUTY_WIDTH-1:0] speed_cmd;
    logic                  dir_cmd;
    logic                  switch_pressed;
    logic                  stall_flag;
  } in_t;

  typedef struct packed {
    logic [1:0]            phase_code;
    logic [DUTY_WIDTH-1:0] duty_cycle;
    logic [DUTY_WIDTH-1:0] target_speed;
    logic                  direction;
    logic [1:0]            drive_cmd;
    logic                  precharge_pulse;
    logic                  gate_enable;
    logic                  led_on;
    logic                  clear_stall;
  } out_t;

endpackage

`default_nettype wire

### rtl/mdr_cfg_regs.sv
`default_nettype none

module mdr_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [mdr_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
  input  wire logic [mdr_pkg::DUTY_WIDTH-1:0]       cfg_wdata,
  output mdr_pkg::cfg_t                             cfg
);

  mdr_pkg::cfg_t cfg_r;

  // Register file, written by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_step        <= mdr_pkg::RAMP_STEP_RST;
      cfg_r.duty_floor       <= mdr_pkg::DUTY_FLOOR_RST;
      cfg_r.test_duty        <= mdr_pkg::TEST_DUTY_RST;
      cfg_r.fault_hold_ticks <= mdr_pkg::FAULT_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mdr_pkg::CFG_RAMP_STEP:  cfg_r.ramp_step        <= cfg_wdata;
        mdr_pkg::CFG_DUTY_FLOOR: cfg_r.duty_floor       <= cfg_wdata;
        mdr_pkg::CFG_TEST_DUTY:  cfg_r.test_duty        <= cfg_wdata;
        mdr_pkg::CFG_FAULT_HOLD: cfg_r.fault_hold_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/mdr_engine.sv
`default_nettype none

module mdr_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire mdr_pkg::cfg_t cfg,
  input  wire mdr_pkg::in_t  tick,
  output mdr_pkg::out_t      res
);

  typedef enum logic [1:0] {
    ST_STOPPED  = 2'd0,
    ST_STARTING = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_FAULT    = 2'd3
  } phase_t;

  localparam int unsigned W = mdr_pkg::DUTY_WIDTH;

  phase_t         phase_r, phase_nxt;
  logic [1:0]     rep_r, rep_nxt;
  logic [W-1:0]   duty_r, duty_nxt;
  logic [W-1:0]   target_r, target_nxt;
  logic [W-1:0]   hold_r, hold_nxt;
  logic           dir_r, dir_nxt;
  logic           led_r, led_nxt;
  logic           gate_r, gate_nxt;

  logic [W:0]     up_sum;
  logic [W-1:0]   duty_up;
  logic [W-1:0]   duty_dn;
  logic           rep_dir;
  logic [1:0]     drive;
  logic           pre;
  logic           clr;

  // Saturating step up and down by the ramp step
  assign up_sum  = {1'b0, duty_r} + {1'b0, cfg.ramp_step};
  assign duty_up = up_sum[W] ? mdr_pkg::DUTY_MAX : up_sum[W-1:0];
  assign duty_dn = (duty_r > cfg.ramp_step) ? (duty_r - cfg.ramp_step) : '0;

  // Next state and result for one tick
  always_comb begin
    phase_nxt  = phase_r;
    rep_nxt    = rep_r;
    duty_nxt   = duty_r;
    hold_nxt   = hold_r;
    dir_nxt    = dir_r;
    led_nxt    = led_r;
    gate_nxt   = gate_r;
    rep_dir    = tick.dir_cmd;
    drive      = mdr_pkg::DRV_NONE;
    pre        = 1'b0;
    clr        = 1'b0;
    target_nxt = (tick.start_cmd && (tick.speed_cmd != '0)) ? tick.speed_cmd : target_r;

    unique case (phase_r)
      ST_STOPPED: begin
        drive   = mdr_pkg::DRV_DISABLE;
        rep_nxt = mdr_pkg::MST_STOPPED;
        clr     = 1'b1;
        if (tick.start_cmd || tick.switch_pressed) begin
          phase_nxt = ST_STARTING;
          // switch start reports and holds the inverted direction
          if (tick.switch_pressed) begin
            rep_dir = ~tick.dir_cmd;
            dir_nxt = ~tick.dir_cmd;
          end
        end
      end
      ST_STARTING: begin
        dir_nxt   = tick.dir_cmd;
        led_nxt   = 1'b1;
        gate_nxt  = 1'b1;
        rep_nxt   = mdr_pkg::MST_STARTING;
        pre       = 1'b1;
        drive     = mdr_pkg::DRV_ENABLE;
        phase_nxt = ST_RUNNING;
      end
      ST_RUNNING: begin
        if (tick.stall_flag) begin
          rep_nxt   = mdr_pkg::MST_FAULT;
          hold_nxt  = cfg.fault_hold_ticks;
          phase_nxt = ST_FAULT;
        end else begin
          rep_nxt = mdr_pkg::MST_RUNNING;
          if (!tick.start_cmd && tick.switch_pressed) begin
            // switch drive ramps up while the duty is below the test duty
            if (duty_r < cfg.test_duty) duty_nxt = duty_up;
          end else if (!tick.start_cmd) begin
            phase_nxt = ST_STOPPED;
          end else if (target_nxt < cfg.duty_floor) begin
            duty_nxt = cfg.duty_floor;
          end else if (duty_r < target_nxt) begin
            duty_nxt = duty_up;
            led_nxt  = ~led_r;
          end else if (duty_r > target_nxt) begin
            duty_nxt = duty_dn;
          end else begin
            duty_nxt = target_nxt;
          end
        end
      end
      ST_FAULT: begin
        drive = mdr_pkg::DRV_RESET;
        if (hold_r == '0) phase_nxt = ST_STOPPED;
        else              hold_nxt  = hold_r - 1'b1;
      end
      default: ;
    endcase
  end

  // State update, one tick per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ST_STOPPED;
      rep_r    <= mdr_pkg::MST_STOPPED;
      duty_r   <= '0;
      target_r <= '0;
      hold_r   <= '0;
      dir_r    <= 1'b0;
      led_r    <= 1'b0;
      gate_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      rep_r    <= rep_nxt;
      duty_r   <= duty_nxt;
      target_r <= target_nxt;
      hold_r   <= hold_nxt;
      dir_r    <= dir_nxt;
      led_r    <= led_nxt;
      gate_r   <= gate_nxt;
    end
  end

  // Result fields after this tick
  always_comb begin
    res.phase_code      = rep_nxt;
    res.duty_cycle      = duty_nxt;
    res.target_speed    = target_nxt;
    res.direction       = rep_dir;
    res.drive_cmd       = drive;
    res.precharge_pulse = pre;
    res.gate_enable     = gate_nxt;
    res.led_on          = led_nxt;
    res.clear_stall     = clr;
  end

endmodule

`default_nettype wire

### rtl/motor_duty_ramp_state_machine_unit.sv
// Motor duty ramp state machine, one control tick per beat.
// An accepted input beat is taken into the input register, then its result into the result register.
// Throughput: 1 beat per cycle while the result is not stalled; input register, state update and result register.
// Input stalls only while both registers hold a beat and the result is stalled.
// Reset (rst_n low, synchronous): stopped, duty/target/counters zero, config defaults.
`default_nettype none

module motor_duty_ramp_state_machine_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire mdr_pkg::in_t                       in_data,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output mdr_pkg::out_t                           out_data,
  input  wire logic                               cfg_we,
  input  wire logic [mdr_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  wire logic [mdr_pkg::DUTY_WIDTH-1:0]     cfg_wdata
);

  logic          in_v_r;
  mdr_pkg::in_t  in_d_r;
  logic          out_v_r;
  mdr_pkg::out_t out_d_r;
  logic          adv;
  logic          step;
  mdr_pkg::cfg_t cfg;
  mdr_pkg::out_t res;

  mdr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mdr_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg),
    .tick  (in_d_r),
    .res   (res)
  );

  // Pipeline flow control
  assign adv      = !out_v_r || !out_stall;
  assign step     = in_v_r && adv;
  assign in_stall = in_v_r && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_d_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_d_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

`default_nettype wire
